/* rtl/pmd_pkg.sv */
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the peer message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

    localparam int PieceCountWidth = 21;
    localparam int BlockLimitWidth = 18;
    localparam int QueueDepthDefault = 2;

    localparam logic [PieceCountWidth-1:0] PieceCountReset = 21'd1;
    localparam logic [BlockLimitWidth-1:0] BlockLimitReset = 18'd16384;

    localparam logic [0:0] REG_PIECE_COUNT = 1'b0;
    localparam logic [0:0] REG_BLOCK_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        KIND_KEEPALIVE = 4'd0,
        KIND_CONTROL   = 4'd1,
        KIND_HAVE      = 4'd2,
        KIND_REQUEST   = 4'd3,
        KIND_PORT      = 4'd4,
        KIND_BITFIELD  = 4'd5,
        KIND_PIECE_HDR = 4'd6,
        KIND_PIECE     = 4'd7,
        KIND_ERROR     = 4'd8
    } kind_t;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TYPE   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    localparam logic [3:0] TYPE_HAVE     = 4'd4;
    localparam logic [3:0] TYPE_BITFIELD = 4'd5;
    localparam logic [3:0] TYPE_REQUEST  = 4'd6;
    localparam logic [3:0] TYPE_PIECE    = 4'd7;
    localparam logic [3:0] TYPE_CANCEL   = 4'd8;
    localparam logic [3:0] TYPE_PORT     = 4'd9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  msg_code;
        logic [31:0] field_index;
        logic [31:0] field_begin;
        logic [31:0] field_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic [1:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

/* rtl/pmd_front.sv */
// ----------------------------------------------------------------------------
// pmd_front
// Parses the byte stream and forms one result per byte where one is due.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [pmd_pkg::PieceCountWidth-1:0] piece_count,
    input  wire logic [pmd_pkg::BlockLimitWidth-1:0] block_limit,
    input  wire logic                                in_valid,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_resync,
    output pmd_pkg::result_t                         res,
    output logic                                     res_valid
);
    import pmd_pkg::*;

    typedef enum logic [4:0] {
        PH_LEN     = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_FIELDS  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_ERROR   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] left_reg, left_next;
    logic [3:0]  type_reg, type_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        len_ok;
    logic [31:0] bf_len, pc_max;
    logic [3:0]  fbytes;
    logic [31:0] len_shift;

    assign bf_len    = 32'd1 + 32'(({11'd0, piece_count} + 32'd7) >> 3);
    assign pc_max    = 32'd9 + 32'(block_limit);
    assign len_shift = {len_reg[23:0], in_byte};

    always_comb begin
        case (in_byte[3:0])
            TYPE_HAVE:     len_ok = (len_reg == 32'd5);
            TYPE_BITFIELD: len_ok = (len_reg == bf_len);
            TYPE_REQUEST:  len_ok = (len_reg == 32'd13);
            TYPE_PIECE:    len_ok = (len_reg >= 32'd10) && (len_reg <= pc_max);
            TYPE_PORT:     len_ok = (len_reg == 32'd3);
            default:       len_ok = (len_reg == 32'd1);
        endcase
        case (type_reg)
            TYPE_HAVE:    fbytes = 4'd4;
            TYPE_REQUEST: fbytes = 4'd12;
            TYPE_PIECE:   fbytes = 4'd8;
            default:      fbytes = 4'd2;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        type_next  = type_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        res        = '0;
        res_valid  = 1'b0;
        if (in_valid) begin
            if (in_resync) begin
                phase_next = PH_LEN;
                len_next   = '0;
                left_next  = '0;
                cnt_next   = '0;
            end else begin
                unique case (phase_reg)
                    PH_LEN: begin
                        len_next = len_shift;
                        cnt_next = cnt_reg + 4'd1;
                        if (cnt_reg == 4'd3) begin
                            cnt_next = '0;
                            if (len_shift == 32'd0) begin
                                res_valid = 1'b1;
                                res.kind  = KIND_KEEPALIVE;
                            end else begin
                                phase_next = PH_TYPE;
                            end
                        end
                    end
                    PH_TYPE: begin
                        if (in_byte >= 8'd10) begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TYPE;
                        end else if (!len_ok) begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.msg_code   = in_byte[3:0];
                            res.error_code = ERR_LENGTH;
                        end else if (in_byte[3:0] == TYPE_CANCEL) begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.msg_code   = TYPE_CANCEL;
                            res.error_code = ERR_TYPE;
                        end else begin
                            type_next = in_byte[3:0];
                            if (in_byte < 8'd4) begin
                                phase_next   = PH_LEN;
                                len_next     = '0;
                                left_next    = '0;
                                cnt_next     = '0;
                                res_valid    = 1'b1;
                                res.kind     = KIND_CONTROL;
                                res.msg_code = in_byte[3:0];
                            end else if (in_byte[3:0] == TYPE_BITFIELD) begin
                                left_next = len_reg - 32'd1;
                                if (len_reg == 32'd1) begin
                                    phase_next = PH_LEN;
                                    len_next   = '0;
                                    cnt_next   = '0;
                                end else begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end else begin
                                a_next     = '0;
                                b_next     = '0;
                                c_next     = '0;
                                cnt_next   = '0;
                                phase_next = PH_FIELDS;
                            end
                        end
                    end
                    PH_FIELDS: begin
                        case (cnt_reg[3:2])
                            2'd0:    a_next = {a_reg[23:0], in_byte};
                            2'd1:    b_next = {b_reg[23:0], in_byte};
                            default: c_next = {c_reg[23:0], in_byte};
                        endcase
                        cnt_next = cnt_reg + 4'd1;
                        if (cnt_next == fbytes) begin
                            res_valid    = 1'b1;
                            res.msg_code = type_reg;
                            if (type_reg == TYPE_PIECE) begin
                                left_next        = len_reg - 32'd9;
                                cnt_next         = '0;
                                phase_next       = PH_PAYLOAD;
                                res.kind         = KIND_PIECE_HDR;
                                res.field_index  = a_reg;
                                res.field_begin  = b_next;
                                res.field_length = len_reg - 32'd9;
                            end else begin
                                phase_next = PH_LEN;
                                len_next   = '0;
                                left_next  = '0;
                                cnt_next   = '0;
                                if (type_reg == TYPE_HAVE) begin
                                    res.kind        = KIND_HAVE;
                                    res.field_index = a_next;
                                end else if (type_reg == TYPE_REQUEST) begin
                                    res.kind         = KIND_REQUEST;
                                    res.field_index  = a_reg;
                                    res.field_begin  = b_reg;
                                    res.field_length = c_next;
                                end else begin
                                    res.kind        = KIND_PORT;
                                    res.field_index = {16'd0, a_next[15:0]};
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        left_next        = left_reg - 32'd1;
                        res_valid        = 1'b1;
                        res.kind         = (type_reg == TYPE_PIECE) ? KIND_PIECE : KIND_BITFIELD;
                        res.msg_code     = type_reg;
                        res.payload_byte = in_byte;
                        res.last         = (left_reg == 32'd1);
                        if (left_reg == 32'd1) begin
                            phase_next = PH_LEN;
                            len_next   = '0;
                            cnt_next   = '0;
                        end
                    end
                    PH_ERROR: begin
                    end
                    default: begin
                        phase_next = PH_LEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEN;
            len_reg   <= '0;
            left_reg  <= '0;
            type_reg  <= '0;
            cnt_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            type_reg  <= type_next;
            cnt_reg   <= cnt_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pmd_queue.sv */
// ----------------------------------------------------------------------------
// pmd_queue
// Short result queue between the parser and the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_queue #(
    parameter int Depth = pmd_pkg::QueueDepthDefault
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire pmd_pkg::result_t wr_data,
    output logic                  wr_ready,
    output logic                  rd_valid,
    output pmd_pkg::result_t      rd_data,
    input  wire logic             rd_en
);
    import pmd_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    result_t        mem_reg [Depth];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic           do_wr, do_rd;

    assign wr_ready = (cnt_reg != (AW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (do_rd) begin
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

endmodule

`default_nettype wire

/* rtl/peer_message_deframer.sv */
// A result enters the registered result queue with the byte that completes it; the queue drives m_.
// Throughput: one byte per cycle; s_ready drops only while the 2-entry result queue is full.
// Each byte is parsed combinationally by the front parser; the queue decouples output stalls.
// Reset (aresetn low, synchronous): parser waits for a length prefix, queue empties,
// piece_count returns to 1 and block_limit to 16384.
// ----------------------------------------------------------------------------
// peer_message_deframer
// Splits a peer-wire byte stream into message results.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_message_deframer #(
    parameter int QueueDepth = pmd_pkg::QueueDepthDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [20:0]  cfg_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_resync,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [3:0]        m_kind,
    output logic [3:0]        m_msg_code,
    output logic [31:0]       m_field_index,
    output logic [31:0]       m_field_begin,
    output logic [31:0]       m_field_length,
    output logic [7:0]        m_payload_byte,
    output logic              m_last,
    output logic [1:0]        m_error_code
);
    import pmd_pkg::*;

    logic [PieceCountWidth-1:0] piece_count_reg;
    logic [BlockLimitWidth-1:0] block_limit_reg;
    result_t                    fr_res, q_res;
    logic                       fr_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piece_count_reg <= PieceCountReset;
            block_limit_reg <= BlockLimitReset;
        end else if (cfg_we) begin
            if (cfg_index == REG_PIECE_COUNT) begin
                piece_count_reg <= cfg_data;
            end else begin
                block_limit_reg <= cfg_data[BlockLimitWidth-1:0];
            end
        end
    end

    assign s_ready = q_ready;

    pmd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .piece_count (piece_count_reg),
        .block_limit (block_limit_reg),
        .in_valid    (s_valid && s_ready),
        .in_byte     (s_data_byte),
        .in_resync   (s_resync),
        .res         (fr_res),
        .res_valid   (fr_valid)
    );

    pmd_queue #(.Depth(QueueDepth)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fr_valid),
        .wr_data  (fr_res),
        .wr_ready (q_ready),
        .rd_valid (m_valid),
        .rd_data  (q_res),
        .rd_en    (m_ready)
    );

    assign m_kind         = q_res.kind;
    assign m_msg_code     = q_res.msg_code;
    assign m_field_index  = q_res.field_index;
    assign m_field_begin  = q_res.field_begin;
    assign m_field_length = q_res.field_length;
    assign m_payload_byte = q_res.payload_byte;
    assign m_last         = q_res.last;
    assign m_error_code   = q_res.error_code;

endmodule

`default_nettype wire

/* rtl/pmd_checker.sv */
// ----------------------------------------------------------------------------
// pmd_checker
// Port-level checks for the peer message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_kind,
    input wire logic [1:0]  m_error_code,
    input wire logic        m_last
);
    import pmd_pkg::*;

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_ERROR) == (m_error_code != ERR_NONE)))
        else $error("error code mismatch");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_kind == KIND_BITFIELD || m_kind == KIND_PIECE))
        else $error("last on non-payload item");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind)))
        else $error("output item changed while stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty queue");

endmodule

bind peer_message_deframer pmd_checker u_pmd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_error_code (m_error_code),
    .m_last       (m_last)
);

`default_nettype wire

/* bench/peer_message_deframer_tb.sv */
// ----------------------------------------------------------------------------
// peer_message_deframer_tb
// Feeds peer-wire byte streams into the deframer. The streams hold every
// message type, keepalives, length and type errors, and resyncs. Each result
// is checked against a cycle-free software parser. Configuration is changed
// between phases, and the sender and receiver idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_message_deframer_tb;
    import pmd_pkg::*;

    localparam int PH_LEN = 0, PH_TYPE = 1, PH_FIELDS = 2, PH_PAYLOAD = 3, PH_ERROR = 4;

    typedef struct {
        logic [7:0] data;
        logic       resync;
        logic       has_exp;
        result_t    exp;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [20:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = '0;
    logic s_resync = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [3:0] m_kind;
    logic [3:0] m_msg_code;
    logic [31:0] m_field_index;
    logic [31:0] m_field_begin;
    logic [31:0] m_field_length;
    logic [7:0] m_payload_byte;
    logic m_last;
    logic [1:0] m_error_code;

    peer_message_deframer dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_resync(s_resync), .m_valid(m_valid),
        .m_ready(m_ready), .m_kind(m_kind), .m_msg_code(m_msg_code),
        .m_field_index(m_field_index), .m_field_begin(m_field_begin),
        .m_field_length(m_field_length), .m_payload_byte(m_payload_byte),
        .m_last(m_last), .m_error_code(m_error_code)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // parser state
    logic [20:0] pieces;
    logic [17:0] blk_limit;
    int unsigned ph;
    logic [31:0] msg_len, left, acc_a, acc_b, acc_c;
    logic [3:0] cur_t, nfield;

    result_t expected_results[$];
    int mismatches = 0;
    int results_seen = 0;
    int sent_items = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;

    function automatic result_t mk(logic [3:0] k, logic [3:0] c, logic [31:0] a,
                                   logic [31:0] b, logic [31:0] l, logic [7:0] pb,
                                   logic lst, logic [1:0] e);
        result_t r;
        r.kind = k; r.msg_code = c; r.field_index = a; r.field_begin = b;
        r.field_length = l; r.payload_byte = pb; r.last = lst; r.error_code = e;
        return r;
    endfunction

    function automatic bit len_valid(logic [3:0] t, logic [31:0] len);
        case (t)
            TYPE_HAVE:     return len == 5;
            TYPE_BITFIELD: return len == 1 + ((32'(pieces) + 7) >> 3);
            TYPE_REQUEST:  return len == 13;
            TYPE_PIECE:    return len >= 10 && len <= 9 + 32'(blk_limit);
            TYPE_PORT:     return len == 3;
            default:       return len == 1;
        endcase
    endfunction

    task automatic restart_parse();
        ph = PH_LEN; msg_len = 0; left = 0; nfield = 0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic rs);
        logic [3:0] need;
        if (rs) begin
            restart_parse();
            return;
        end
        case (ph)
            PH_LEN: begin
                msg_len = {msg_len[23:0], b};
                nfield++;
                if (nfield == 4) begin
                    nfield = 0;
                    if (msg_len == 0) begin
                        restart_parse();
                        expected_results.push_back(mk(KIND_KEEPALIVE, 0, 0, 0, 0, 0, 0, ERR_NONE));
                    end else ph = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (b >= 10) begin
                    ph = PH_ERROR;
                    expected_results.push_back(mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_TYPE));
                end else if (!len_valid(b[3:0], msg_len)) begin
                    ph = PH_ERROR;
                    expected_results.push_back(mk(KIND_ERROR, b[3:0], 0, 0, 0, 0, 0, ERR_LENGTH));
                end else if (b[3:0] == TYPE_CANCEL) begin
                    ph = PH_ERROR;
                    expected_results.push_back(mk(KIND_ERROR, b[3:0], 0, 0, 0, 0, 0, ERR_TYPE));
                end else begin
                    cur_t = b[3:0];
                    if (b <= 3) begin
                        restart_parse();
                        expected_results.push_back(mk(KIND_CONTROL, cur_t, 0, 0, 0, 0, 0, ERR_NONE));
                    end else if (cur_t == TYPE_BITFIELD) begin
                        left = msg_len - 1;
                        if (left == 0) restart_parse();
                        else ph = PH_PAYLOAD;
                    end else begin
                        acc_a = 0; acc_b = 0; acc_c = 0; nfield = 0;
                        ph = PH_FIELDS;
                    end
                end
            end
            PH_FIELDS: begin
                case (nfield >> 2)
                    0: acc_a = {acc_a[23:0], b};
                    1: acc_b = {acc_b[23:0], b};
                    default: acc_c = {acc_c[23:0], b};
                endcase
                nfield++;
                need = cur_t == TYPE_HAVE ? 4 : cur_t == TYPE_REQUEST ? 12 :
                       cur_t == TYPE_PIECE ? 8 : 2;
                if (nfield >= need) begin
                    if (cur_t == TYPE_PIECE) begin
                        left = msg_len - 9; nfield = 0; ph = PH_PAYLOAD;
                        expected_results.push_back(mk(KIND_PIECE_HDR, TYPE_PIECE, acc_a, acc_b,
                                                      left, 0, 0, ERR_NONE));
                    end else begin
                        restart_parse();
                        if (cur_t == TYPE_HAVE)
                            expected_results.push_back(mk(KIND_HAVE, TYPE_HAVE, acc_a, 0, 0, 0, 0,
                                                          ERR_NONE));
                        else if (cur_t == TYPE_REQUEST)
                            expected_results.push_back(mk(KIND_REQUEST, TYPE_REQUEST, acc_a, acc_b,
                                                          acc_c, 0, 0, ERR_NONE));
                        else
                            expected_results.push_back(mk(KIND_PORT, TYPE_PORT,
                                                          {16'd0, acc_a[15:0]}, 0, 0, 0, 0,
                                                          ERR_NONE));
                    end
                end
            end
            PH_PAYLOAD: begin
                left--;
                expected_results.push_back(mk(cur_t == TYPE_PIECE ? KIND_PIECE : KIND_BITFIELD,
                                              cur_t, 0, 0, 0, b, left == 0, ERR_NONE));
                if (left == 0) restart_parse();
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [7:0] b, input logic rs);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_resync <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b, rs);
        sent_items++;
    endtask

    // byte stream under construction
    logic [8:0] stream[$];

    task automatic add_len(input logic [31:0] l);
        for (int i = 3; i >= 0; i--) stream.push_back({1'b0, l[8*i +: 8]});
    endtask

    task automatic add_bytes(input int n);
        for (int i = 0; i < n; i++) stream.push_back({1'b0, 8'($urandom)});
    endtask

    task automatic add_message();
        int unsigned pick, n;
        logic [31:0] bf_len;
        pick = $urandom_range(99);
        bf_len = 1 + ((32'(pieces) + 7) >> 3);
        if (pick < 8) add_len(0);
        else if (pick < 20) begin add_len(1); stream.push_back(9'($urandom_range(3))); end
        else if (pick < 32) begin
            add_len(5); stream.push_back({5'd0, TYPE_HAVE}); add_bytes(4);
        end else if (pick < 44) begin
            add_len(13); stream.push_back({5'd0, TYPE_REQUEST}); add_bytes(12);
        end else if (pick < 54) begin
            add_len(3); stream.push_back({5'd0, TYPE_PORT}); add_bytes(2);
        end else if (pick < 66 && bf_len <= 40) begin
            add_len(bf_len); stream.push_back({5'd0, TYPE_BITFIELD}); add_bytes(bf_len - 1);
        end else if (pick < 82 && blk_limit != 0) begin
            n = $urandom_range(1, blk_limit < 24 ? blk_limit : 24);
            add_len(9 + n); stream.push_back({5'd0, TYPE_PIECE}); add_bytes(8 + n);
        end else if (pick < 92) begin
            // likely malformed: random length, random type or cancel, then resync
            add_len($urandom_range(3) == 0 ? $urandom : $urandom_range(1, 14));
            stream.push_back($urandom_range(1) ? 9'($urandom_range(255)) : 9'(TYPE_CANCEL));
            add_bytes($urandom_range(3));
            stream.push_back({1'b1, 8'($urandom)});
        end else begin
            add_bytes($urandom_range(1, 6));
            stream.push_back({1'b1, 8'($urandom)});
        end
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [20:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_PIECE_COUNT) pieces = v;
        else blk_limit = v[17:0];
        @(posedge aclk);
    endtask

    task automatic run_random(input int n, input int si, input int rs);
        send_idle = si;
        recv_stall = rs;
        for (int i = 0; i < n; ) begin
            if (stream.size() == 0) add_message();
            send_item(stream[0][7:0], stream[0][8]);
            void'(stream.pop_front());
            i++;
        end
        while (stream.size() != 0) begin
            send_item(stream[0][7:0], stream[0][8]);
            void'(stream.pop_front());
        end
        send_item(8'h00, 1'b1);
        drain_and_idle();
    endtask

    // receiver
    always @(posedge aclk) begin
        if (!aresetn || hold_off > 0) begin
            m_ready <= 1'b0;
            if (hold_off > 0) hold_off <= hold_off - 1;
        end else begin
            m_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
        end
        if (aresetn && m_valid && m_ready) begin
            result_t got, want;
            got = {m_kind, m_msg_code, m_field_index, m_field_begin, m_field_length,
                   m_payload_byte, m_last, m_error_code};
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    row_t directed[$];

    task automatic row(input logic [7:0] d, input logic rs = 0, input bit he = 0,
                       input result_t e = '0);
        row_t r;
        r.data = d; r.resync = rs; r.has_exp = he; r.exp = e;
        directed.push_back(r);
    endtask

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int qsz;
        pieces = PieceCountReset;
        blk_limit = BlockLimitReset;
        restart_parse();
        cur_t = 0; acc_a = 0; acc_b = 0; acc_c = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keepalive, control, bad type, cancel, have extremes, bitfield, port
        row(0); row(0); row(0); row(0, 0, 1, mk(KIND_KEEPALIVE, 0, 0, 0, 0, 0, 0, ERR_NONE));
        row(0); row(0); row(0); row(1); row(3, 0, 1, mk(KIND_CONTROL, 3, 0, 0, 0, 0, 0, ERR_NONE));
        row(0); row(0); row(0); row(1);
        row(8'hff, 0, 1, mk(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_TYPE));
        row(8'h55); row(0, 1);
        row(0); row(0); row(0); row(1);
        row(8'(TYPE_CANCEL), 0, 1, mk(KIND_ERROR, TYPE_CANCEL, 0, 0, 0, 0, 0, ERR_TYPE));
        row(0, 1);
        row(8'hff); row(8'hff); row(8'hff); row(8'hff);
        row(8'(TYPE_HAVE), 0, 1, mk(KIND_ERROR, TYPE_HAVE, 0, 0, 0, 0, 0, ERR_LENGTH));
        row(0, 1);
        row(0); row(0); row(0); row(5); row(8'(TYPE_HAVE));
        row(8'hff); row(8'hff); row(8'hff);
        row(8'hff, 0, 1, mk(KIND_HAVE, TYPE_HAVE, 32'hffffffff, 0, 0, 0, 0, ERR_NONE));
        row(0); row(0); row(0); row(2); row(8'(TYPE_BITFIELD));
        row(8'ha5, 0, 1, mk(KIND_BITFIELD, TYPE_BITFIELD, 0, 0, 0, 8'ha5, 1, ERR_NONE));
        row(0); row(0); row(0); row(3); row(8'(TYPE_PORT)); row(8'h12); row(8'h34);

        foreach (directed[i]) begin
            qsz = expected_results.size();
            send_item(directed[i].data, directed[i].resync);
            if (directed[i].has_exp && expected_results.size() == qsz + 1
                    && expected_results[qsz] !== directed[i].exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %h got %h", i, directed[i].exp,
                             expected_results[qsz]);
            end
        end
        drain_and_idle();

        run_random(150, 0, 0);
        write_cfg(REG_PIECE_COUNT, 21'd0);
        write_cfg(REG_BLOCK_LIMIT, 21'd0);
        run_random(250, 83, 0);
        write_cfg(REG_PIECE_COUNT, 21'd1048576);
        write_cfg(REG_BLOCK_LIMIT, 21'd1);
        run_random(250, 0, 83);
        write_cfg(REG_PIECE_COUNT, 21'd200);
        write_cfg(REG_BLOCK_LIMIT, 21'd131072);
        run_random(250, 34, 34);
        write_cfg(REG_PIECE_COUNT, 21'h1fffff);
        write_cfg(REG_BLOCK_LIMIT, 21'h3ffff);
        hold_off = 200;
        run_random(300, 0, 0);

        $display("%0d items sent, %0d results checked over keepalive, control, field,",
                 sent_items, results_seen);
        $display("payload and error messages under five register settings");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

/* files.f */
rtl/pmd_pkg.sv
rtl/pmd_front.sv
rtl/pmd_queue.sv
rtl/peer_message_deframer.sv
rtl/pmd_checker.sv
bench/peer_message_deframer_tb.sv
